/* rtl/mps_pkg.sv */
// Package with the shared types, tag codes and helper functions of the MessagePack decoder.
`timescale 1ns / 1ps
`default_nettype none

package mps_pkg;

	localparam int POS_BITS = 32;
	localparam int CMP_BITS = (POS_BITS > 32) ? POS_BITS : 32;
	localparam int LEN_BITS = 32;
	localparam int VAL_BITS = 64;
	localparam int NEED_BITS = 6;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;
	localparam logic [4:0] FIXSTR_LEN_MASK = 5'b11111;

	localparam logic [7:0] TAG_POSFIX_MAX = 8'h7f;
	localparam logic [7:0] TAG_FIXSTR_MIN = 8'ha0;
	localparam logic [7:0] TAG_FIXSTR_MAX = 8'hbf;
	localparam logic [7:0] TAG_NIL = 8'hc0;
	localparam logic [7:0] TAG_FALSE = 8'hc2;
	localparam logic [7:0] TAG_TRUE = 8'hc3;
	localparam logic [7:0] TAG_BIN8 = 8'hc4;
	localparam logic [7:0] TAG_BIN16 = 8'hc5;
	localparam logic [7:0] TAG_BIN32 = 8'hc6;
	localparam logic [7:0] TAG_F32 = 8'hca;
	localparam logic [7:0] TAG_F64 = 8'hcb;
	localparam logic [7:0] TAG_U8 = 8'hcc;
	localparam logic [7:0] TAG_U16 = 8'hcd;
	localparam logic [7:0] TAG_U32 = 8'hce;
	localparam logic [7:0] TAG_U64 = 8'hcf;
	localparam logic [7:0] TAG_I8 = 8'hd0;
	localparam logic [7:0] TAG_I16 = 8'hd1;
	localparam logic [7:0] TAG_I32 = 8'hd2;
	localparam logic [7:0] TAG_I64 = 8'hd3;
	localparam logic [7:0] TAG_STR8 = 8'hd9;
	localparam logic [7:0] TAG_STR16 = 8'hda;
	localparam logic [7:0] TAG_STR32 = 8'hdb;
	localparam logic [7:0] TAG_NEGFIX_MIN = 8'he0;

	typedef enum logic [1:0] {
		PH_TAG     = 2'd0,
		PH_FIELD   = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		KIND_NIL      = 4'd0,
		KIND_FALSE    = 4'd1,
		KIND_TRUE     = 4'd2,
		KIND_SIGNED   = 4'd3,
		KIND_UNSIGNED = 4'd4,
		KIND_F32      = 4'd5,
		KIND_F64      = 4'd6,
		KIND_STR      = 4'd7,
		KIND_BIN      = 4'd8,
		KIND_PAYLOAD  = 4'd9,
		KIND_ERROR    = 4'd10
	} kind_t;

	typedef struct packed {
		logic                valid;
		kind_t               kind;
		logic [VAL_BITS-1:0] value;
		logic [LEN_BITS-1:0] length;
		logic                last;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] n;
	} field_info_t;

	// Number of big-endian field bytes after a tag; ok is low for unsupported tags.
	function automatic field_info_t field_info(input logic [7:0] t);
		field_info_t r;
		r.ok = 1'b1;
		r.n = 4'd0;
		unique case (t)
			TAG_BIN8, TAG_U8, TAG_I8, TAG_STR8: r.n = 4'd1;
			TAG_BIN16, TAG_U16, TAG_I16, TAG_STR16: r.n = 4'd2;
			TAG_BIN32, TAG_F32, TAG_U32, TAG_I32, TAG_STR32: r.n = 4'd4;
			TAG_F64, TAG_U64, TAG_I64: r.n = 4'd8;
			TAG_NIL, TAG_FALSE, TAG_TRUE: r.n = 4'd0;
			default: begin
				r.ok = (t <= TAG_POSFIX_MAX) || ((t >= TAG_FIXSTR_MIN) && (t <= TAG_FIXSTR_MAX)) ||
					(t >= TAG_NEGFIX_MIN);
			end
		endcase
		return r;
	endfunction

	// Bytes left between the position and the end of the buffer, never negative.
	function automatic logic [LEN_BITS-1:0] room_left(input logic [LEN_BITS-1:0] len,
		input logic [POS_BITS-1:0] pos);
		logic [CMP_BITS-1:0] len_ext;
		logic [CMP_BITS-1:0] pos_ext;
		logic [CMP_BITS-1:0] diff;
		len_ext = CMP_BITS'(len);
		pos_ext = CMP_BITS'(pos);
		diff = len_ext - pos_ext;
		if (pos_ext >= len_ext) begin
			return '0;
		end
		return diff[LEN_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/msgpack_scalar_decoder.sv */
// Top level of the streaming MessagePack scalar decoder with input and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Streaming MessagePack scalar decoder. One buffer byte is taken per request on the input
// channel, and a new byte can be accepted in every clock cycle unless the result register
// is full and out_ready is low; each byte gives at most one result. A byte is decoded while
// it sits in the input register and its result is written into the result register at the
// next clock edge at which that register is empty or being emptied. The rate is set by the
// update of the decoder state in mps_core. Tag bytes that carry big-endian field bytes give
// no result until the last field byte; string and binary payload bytes each give one. Write
// buffer_length through cfg_we/cfg_wdata while the block is idle.
module msgpack_scalar_decoder import mps_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [LEN_BITS-1:0] cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          in_byte,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [3:0]               out_kind,
	output logic [VAL_BITS-1:0]      out_value,
	output logic [LEN_BITS-1:0]      out_length,
	output logic                     out_element_end
);

	logic [LEN_BITS-1:0] buffer_length_q;
	logic [7:0]          byte_s1;
	logic                valid_s1;
	logic                step_go;
	result_t             res;
	result_t             res_s2;
	logic                valid_s2;

	// Stage 1 moves on whenever the result register is empty or being emptied.
	assign step_go = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= '0;
		end else if (cfg_we) begin
			buffer_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	mps_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (step_go),
		.byte_in       (byte_s1),
		.buffer_length (buffer_length_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step_go) begin
			valid_s2 <= res.valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && res.valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_kind = res_s2.kind;
	assign out_value = res_s2.value;
	assign out_length = res_s2.length;
	assign out_element_end = res_s2.last;

endmodule

`default_nettype wire

/* rtl/mps_core.sv */
// Decoder state registers and the combinational next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module mps_core import mps_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step_en,
	input  wire logic [7:0]          byte_in,
	input  wire logic [LEN_BITS-1:0] buffer_length,
	output result_t                  res
);

	phase_t              phase_q, phase_n;
	logic [7:0]          tag_q, tag_n;
	logic [3:0]          left_q, left_n;
	logic [VAL_BITS-1:0] acc_q, acc_n;
	logic [LEN_BITS-1:0] pl_q, pl_n;
	logic [POS_BITS-1:0] pos_q, pos_n;
	logic                err_q, err_n;

	logic [POS_BITS-1:0]  pos_inc;
	logic [LEN_BITS-1:0]  room_now;
	logic [LEN_BITS-1:0]  room_after;
	logic [VAL_BITS-1:0]  acc_new;
	logic [VAL_BITS-1:0]  sext;
	logic [LEN_BITS-1:0]  hdr_len;
	logic [LEN_BITS-1:0]  fix_len;
	logic [NEED_BITS-1:0] need;
	field_info_t          tag_info;

	assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + POS_BITS'(1);
	assign room_now = room_left(buffer_length, pos_q);
	assign room_after = room_left(buffer_length, pos_inc);
	assign acc_new = {acc_q[VAL_BITS-9:0], byte_in};
	assign hdr_len = acc_new[LEN_BITS-1:0];
	assign tag_info = field_info(byte_in);
	assign fix_len = LEN_BITS'(byte_in[4:0] & FIXSTR_LEN_MASK);

	always_comb begin
		need = NEED_BITS'(1) + NEED_BITS'(tag_info.n);
		if ((byte_in >= TAG_FIXSTR_MIN) && (byte_in <= TAG_FIXSTR_MAX)) begin
			need = need + NEED_BITS'(byte_in[4:0] & FIXSTR_LEN_MASK);
		end
	end

	// Sign extension by the field width of int8 through int64.
	always_comb begin
		unique case (tag_q[1:0])
			2'd0: sext = {{56{acc_new[7]}}, acc_new[7:0]};
			2'd1: sext = {{48{acc_new[15]}}, acc_new[15:0]};
			2'd2: sext = {{32{acc_new[31]}}, acc_new[31:0]};
			default: sext = acc_new;
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		tag_n = tag_q;
		left_n = left_q;
		acc_n = acc_q;
		pl_n = pl_q;
		pos_n = pos_q;
		err_n = err_q;
		res = '0;
		res.kind = KIND_NIL;
		if (err_q) begin
			res.valid = 1'b1;
			res.kind = KIND_ERROR;
			res.last = 1'b1;
		end else begin
			unique case (phase_q)
				PH_FIELD: begin
					acc_n = acc_new;
					pos_n = pos_inc;
					left_n = (left_q != 4'd0) ? left_q - 4'd1 : left_q;
					if (left_n == 4'd0) begin
						phase_n = PH_TAG;
						res.valid = 1'b1;
						res.last = 1'b1;
						if ((tag_q >= TAG_I8) && (tag_q <= TAG_I64)) begin
							res.kind = KIND_SIGNED;
							res.value = sext;
						end else if ((tag_q >= TAG_U8) && (tag_q <= TAG_U64)) begin
							res.kind = KIND_UNSIGNED;
							res.value = acc_new;
						end else if (tag_q == TAG_F32) begin
							res.kind = KIND_F32;
							res.value = {32'd0, acc_new[31:0]};
						end else if (tag_q == TAG_F64) begin
							res.kind = KIND_F64;
							res.value = acc_new;
						end else if (hdr_len > room_after) begin
							err_n = 1'b1;
							res.kind = KIND_ERROR;
						end else begin
							pl_n = hdr_len;
							if (hdr_len != '0) begin
								phase_n = PH_PAYLOAD;
							end
							res.kind = (tag_q >= TAG_STR8) ? KIND_STR : KIND_BIN;
							res.length = hdr_len;
							res.last = (hdr_len == '0);
						end
					end
				end
				PH_PAYLOAD: begin
					pos_n = pos_inc;
					pl_n = (pl_q != '0) ? pl_q - LEN_BITS'(1) : pl_q;
					if (pl_n == '0) begin
						phase_n = PH_TAG;
					end
					res.valid = 1'b1;
					res.kind = KIND_PAYLOAD;
					res.value = {56'd0, byte_in};
					res.last = (pl_n == '0);
				end
				default: begin
					phase_n = PH_TAG;
					res.valid = 1'b1;
					res.last = 1'b1;
					if (!tag_info.ok) begin
						// Unsupported tags report the tag itself and do not stop decoding.
						pos_n = pos_inc;
						res.kind = KIND_ERROR;
						res.value = {56'd0, byte_in};
					end else if (LEN_BITS'(need) > room_now) begin
						err_n = 1'b1;
						res.kind = KIND_ERROR;
					end else begin
						pos_n = pos_inc;
						tag_n = byte_in;
						if (tag_info.n != 4'd0) begin
							phase_n = PH_FIELD;
							left_n = tag_info.n;
							acc_n = '0;
							res.valid = 1'b0;
							res.last = 1'b0;
						end else if (byte_in <= TAG_POSFIX_MAX) begin
							res.kind = KIND_UNSIGNED;
							res.value = {56'd0, byte_in};
						end else if (byte_in >= TAG_NEGFIX_MIN) begin
							res.kind = KIND_SIGNED;
							res.value = {{56{1'b1}}, byte_in};
						end else if (byte_in == TAG_NIL) begin
							res.kind = KIND_NIL;
						end else if (byte_in == TAG_FALSE) begin
							res.kind = KIND_FALSE;
						end else if (byte_in == TAG_TRUE) begin
							res.kind = KIND_TRUE;
						end else begin
							pl_n = fix_len;
							if (fix_len != '0) begin
								phase_n = PH_PAYLOAD;
							end
							res.kind = KIND_STR;
							res.length = fix_len;
							res.last = (fix_len == '0);
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			tag_q <= '0;
			left_q <= '0;
			acc_q <= '0;
			pl_q <= '0;
			pos_q <= '0;
			err_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_n;
			tag_q <= tag_n;
			left_q <= left_n;
			acc_q <= acc_n;
			pl_q <= pl_n;
			pos_q <= pos_n;
			err_q <= err_n;
		end
	end

	// Once raised, the range error stays until reset.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("range error flag cleared without reset");

	// The position counter never moves backward.
	a_pos_mono: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> (pos_q >= $past(pos_q)))
		else $error("byte position moved backward");

	// While collecting field bytes at least one byte is still owed.
	a_field_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FIELD) |-> (left_q != 4'd0))
		else $error("field phase with no field bytes left");

	// In the error state every byte reports a zero-valued error.
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> (res.valid && (res.kind == KIND_ERROR) && (res.value == '0)))
		else $error("sticky error did not report an error result");

endmodule

`default_nettype wire
